>>> rtl/mie_pkg.sv
// Shared types and constants for the modular inverse (extended Euclid) block.
package mie_pkg;

    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_ALIGN,
        S_DIV,
        S_FINAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic update;
        logic shift;
        logic div_step;
        logic capture;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rem_zero;
        logic can_shift;
        logic k_zero;
    } t_dp_sts;

endpackage

>>> rtl/modular_inverse_ext_euclid.sv
// Each Euclid step runs an update, then the alignment shifts, then one divide step per quotient bit;
// when the remainder is zero, the result is captured into the output register.
// The divider is a one-bit-per-cycle shift-subtract divider that each Euclid step runs once.
// A new item is taken only after the last one is captured; the next item is taken while the last
// result waits.
// Reset (synchronous, active low) clears the controller and the output valid flag.
module modular_inverse_ext_euclid #(
    parameter int DATA_WIDTH = mie_pkg::DEF_DATA_WIDTH,
    parameter int IN_TW      = ((2 * DATA_WIDTH - 2 + 7) / 8) * 8,
    parameter int OUT_TW     = ((4 * DATA_WIDTH - 2 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,  // value, modulus
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata,  // inverse, common_divisor, coeff_x, coeff_y
    output logic              m_axis_tuser   // coprime
);
    import mie_pkg::*;

    localparam int RW = DATA_WIDTH - 1;

    t_dp_cmd                cmd;
    t_dp_sts                sts;
    logic [RW-1:0]          inverse, common_divisor;
    logic                   coprime;
    logic [DATA_WIDTH-1:0]  coeff_x, coeff_y;

    mie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    mie_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_value          (s_axis_tdata[RW-1:0]),
        .i_modulus        (s_axis_tdata[2*RW-1:RW]),
        .o_sts            (sts),
        .o_inverse        (inverse),
        .o_common_divisor (common_divisor),
        .o_coprime        (coprime),
        .o_coeff_x        (coeff_x),
        .o_coeff_y        (coeff_y)
    );

    assign m_axis_tdata = OUT_TW'({coeff_y, coeff_x, common_divisor, inverse});
    assign m_axis_tuser = coprime;

endmodule

>>> rtl/mie_dpath.sv
// Datapath: remainder/coefficient registers, shift-subtract divider, final reduction.
module mie_dpath #(
    parameter int DATA_WIDTH = mie_pkg::DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  mie_pkg::t_dp_cmd             i_cmd,
    input  logic [DATA_WIDTH-2:0]        i_value,
    input  logic [DATA_WIDTH-2:0]        i_modulus,
    output mie_pkg::t_dp_sts             o_sts,
    output logic [DATA_WIDTH-2:0]        o_inverse,
    output logic [DATA_WIDTH-2:0]        o_common_divisor,
    output logic                         o_coprime,
    output logic signed [DATA_WIDTH-1:0] o_coeff_x,
    output logic signed [DATA_WIDTH-1:0] o_coeff_y
);
    import mie_pkg::*;

    localparam int RW = DATA_WIDTH - 1;
    localparam int KW = $clog2(RW);

    logic [RW-1:0]         r_rold, r_rcur, r_rem, r_d, r_mod;
    logic [KW-1:0]         r_k;
    logic [DATA_WIDTH-1:0] r_sold, r_scur, r_told, r_tcur, r_ps, r_pt;
    logic [RW-1:0]         r_inv, r_gcd;
    logic                  r_cop;
    logic [DATA_WIDTH-1:0] r_x, r_y;

    logic                  take;
    logic [RW-1:0]         rem_sub;
    logic [DATA_WIDTH-1:0] ps_acc, pt_acc;
    logic [DATA_WIDTH-1:0] m_ext, x_add, x_sub, x_red;
    logic                  x_neg, x_ge;
    logic [RW-1:0]         inv_val;

    // quotient bit for the current alignment position
    assign take    = (r_d <= r_rem);
    assign rem_sub = r_rem - r_d;
    // Horner accumulation of q*s_cur and q*t_cur, quotient MSB first
    assign ps_acc  = {r_ps[DATA_WIDTH-2:0], 1'b0} + (take ? r_scur : '0);
    assign pt_acc  = {r_pt[DATA_WIDTH-2:0], 1'b0} + (take ? r_tcur : '0);

    assign o_sts.rem_zero  = (r_rem == '0);
    assign o_sts.can_shift = ({r_d, 1'b0} <= {1'b0, r_rold});
    assign o_sts.k_zero    = (r_k == '0);

    // x lies within [-m, m]; one add or subtract brings it into 0..m-1
    assign m_ext   = {1'b0, r_mod};
    assign x_neg   = r_told[DATA_WIDTH-1];
    assign x_add   = r_told + m_ext;
    assign x_sub   = r_told - m_ext;
    assign x_ge    = !x_neg && (r_told >= m_ext);
    assign x_red   = x_neg ? x_add : (x_ge ? x_sub : r_told);
    assign inv_val = (r_mod == '0) ? '0 : x_red[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // preset so that the first update yields (m, a, 1, 0, 0, 1)
            r_mod  <= i_modulus;
            r_rcur <= i_modulus;
            r_rem  <= i_value;
            r_sold <= '0;
            r_scur <= DATA_WIDTH'(1);
            r_told <= DATA_WIDTH'(1);
            r_tcur <= '0;
            r_ps   <= '0;
            r_pt   <= '0;
        end else if (i_cmd.update) begin
            r_rold <= r_rcur;
            r_rcur <= r_rem;
            r_sold <= r_scur;
            r_scur <= r_sold - r_ps;
            r_told <= r_tcur;
            r_tcur <= r_told - r_pt;
            // set up the next division: r_rcur / r_rem
            r_rem  <= r_rcur;
            r_d    <= r_rem;
            r_k    <= '0;
            r_ps   <= '0;
            r_pt   <= '0;
        end else if (i_cmd.shift) begin
            r_d <= {r_d[RW-2:0], 1'b0};
            r_k <= r_k + KW'(1);
        end else if (i_cmd.div_step) begin
            if (take) begin
                r_rem <= rem_sub;
            end
            r_ps <= ps_acc;
            r_pt <= pt_acc;
            r_d  <= {1'b0, r_d[RW-1:1]};
            r_k  <= r_k - KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_inv <= inv_val;
            r_gcd <= r_rold;
            r_cop <= (r_rold == RW'(1));
            r_x   <= r_told;
            r_y   <= r_sold;
        end
    end

    assign o_inverse        = r_inv;
    assign o_common_divisor = r_gcd;
    assign o_coprime        = r_cop;
    assign o_coeff_x        = r_x;
    assign o_coeff_y        = r_y;

endmodule

>>> rtl/mie_ctrl.sv
// Controller: sequences load, division steps, coefficient updates and result capture.
module mie_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  mie_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output mie_pkg::t_dp_cmd o_cmd
);
    import mie_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = i_sts.rem_zero ? S_FINAL : S_ALIGN;
            end
            S_ALIGN: begin
                if (!i_sts.can_shift) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.k_zero) begin
                    n_state = S_UPDATE;
                end
            end
            S_FINAL: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_UPDATE: o_cmd.update   = 1'b1;
            S_ALIGN:  o_cmd.shift    = i_sts.can_shift;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_FINAL:  o_cmd.capture  = slot_free;
            default:  o_cmd          = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/mie_checker.sv
// Port-level checks for the modular inverse block, bound to the top level.
module mie_checker #(
    parameter int DATA_WIDTH = mie_pkg::DEF_DATA_WIDTH,
    parameter int OUT_TW     = ((4 * DATA_WIDTH - 2 + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);
    localparam int RW = DATA_WIDTH - 1;

    // a result waiting for the sink stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // one item in flight: no transfer in the cycle right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // coprime flag agrees with the divisor
    a_coprime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser == (m_axis_tdata[2*RW-1:RW] == RW'(1)))
        else $error("coprime flag disagrees with divisor");

    // idle and empty right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind modular_inverse_ext_euclid mie_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .OUT_TW     (OUT_TW)
) u_mie_checker (.*);
